[rtl/core/asf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asf_pkg
// shared widths, character codes, job descriptor and helpers of the
// sentence framer
// ----------------------------------------------------------------------------
package asf_pkg;

    localparam int LEN_W    = 11;
    localparam int SEQ_W    = 8;
    localparam int CHAN_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int CHAR_W   = 7;
    localparam int ERR_W    = 2;

    localparam int MAX_BITS_DEF           = 1024;
    localparam int CHARS_PER_FRAGMENT_DEF = 60;
    localparam int MAX_FRAGMENTS_DEF      = 9;
    localparam int QUEUE_DEPTH_DEF        = 4;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    localparam logic [CHAN_W-1:0] CHAN_B_IN = 8'd66;

    localparam logic [CHAR_W-1:0] CH_NUL   = 7'd0;
    localparam logic [CHAR_W-1:0] CH_BANG  = 7'd33;
    localparam logic [CHAR_W-1:0] CH_STAR  = 7'd42;
    localparam logic [CHAR_W-1:0] CH_COMMA = 7'd44;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CH_A     = 7'd65;
    localparam logic [CHAR_W-1:0] CH_B     = 7'd66;
    localparam logic [CHAR_W-1:0] CH_D     = 7'd68;
    localparam logic [CHAR_W-1:0] CH_I     = 7'd73;
    localparam logic [CHAR_W-1:0] CH_M     = 7'd77;
    localparam logic [CHAR_W-1:0] CH_V     = 7'd86;
    localparam logic [CHAR_W-1:0] ARMOR_OFS  = 7'd48;
    localparam logic [CHAR_W-1:0] ARMOR_KNEE = 7'd87;
    localparam logic [CHAR_W-1:0] ARMOR_GAP  = 7'd8;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_NO_MSG = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        JOB_ERR   = 3'b001,
        JOB_START = 3'b010,
        JOB_DATA  = 3'b100
    } t_job_kind;

    typedef struct packed {
        t_job_kind           kind;
        t_err                err;
        logic [CHAR_W-1:0]   character;
        logic                close;
        logic                reopen;
        logic [2:0]          fill;
        logic [3:0]          total;
        logic [3:0]          index;
        logic [3:0]          seq;
        logic                chan_b;
    } t_job;

    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] v);
        logic [CHAR_W-1:0] r;
        if (v < 4'd10) begin
            r = CH_ZERO + {3'b000, v};
        end else begin
            r = CH_A + {3'b000, v} - 7'd10;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/asf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asf_front
// accepts items, checks and sizes messages, masks and armors sextets and
// hands one job per item to the queue
// ----------------------------------------------------------------------------
module asf_front #(
    parameter int MAX_BITS           = asf_pkg::MAX_BITS_DEF,
    parameter int CHARS_PER_FRAGMENT = asf_pkg::CHARS_PER_FRAGMENT_DEF,
    parameter int MAX_FRAGMENTS      = asf_pkg::MAX_FRAGMENTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_op,
    input  wire logic [asf_pkg::LEN_W-1:0]     i_bit_length,
    input  wire logic [asf_pkg::SEQ_W-1:0]     i_seq_id,
    input  wire logic [asf_pkg::CHAN_W-1:0]    i_channel,
    input  wire logic [asf_pkg::SEXTET_W-1:0]  i_sextet,
    input  wire logic                          i_full,
    output logic                               o_push,
    output asf_pkg::t_job                      o_job
);
    import asf_pkg::*;

    localparam int FC_W = $clog2(CHARS_PER_FRAGMENT + 1);

    logic             r_open,      n_open;
    logic [LEN_W-1:0] r_bits_left, n_bits_left;
    logic [FC_W-1:0]  r_frag_cnt,  n_frag_cnt;
    logic [3:0]       r_index,     n_index;
    logic [3:0]       r_total,     n_total;
    logic [3:0]       r_seq,       n_seq;
    logic             r_chan_b,    n_chan_b;

    logic                accept;
    logic                len_bad;
    logic [3:0]          calc_total;
    logic [15:0]         seq_prod;
    logic [4:0]          seq_quot;
    logic [SEQ_W-1:0]    seq_rem;
    logic                pl_last;
    logic                pl_short;
    logic [SEXTET_W-1:0] pl_mask;
    logic [CHAR_W-1:0]   pl_sum;
    logic [CHAR_W-1:0]   pl_char;
    logic [2:0]          pl_fill;
    logic [FC_W-1:0]     frag_next;
    logic                pl_close;
    logic                pl_reopen;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    // fragment count by compare against fragment boundaries in bits
    always_comb begin
        calc_total = 4'd1;
        for (int k = 1; k < MAX_FRAGMENTS; k++) begin
            if (int'(i_bit_length) > k * CHARS_PER_FRAGMENT * 6) begin
                calc_total = calc_total + 4'd1;
            end
        end
    end

    assign len_bad = (i_bit_length == '0) || (int'(i_bit_length) > MAX_BITS)
                  || (int'(i_bit_length) > MAX_FRAGMENTS * CHARS_PER_FRAGMENT * 6);

    // seq_id mod 10 by reciprocal
    assign seq_prod = 16'(i_seq_id) * 16'd205;
    assign seq_quot = seq_prod[15:11];
    assign seq_rem  = i_seq_id - 8'(seq_quot) * 8'd10;

    assign pl_last   = r_bits_left <= LEN_W'(6);
    assign pl_short  = r_bits_left < LEN_W'(6);
    assign pl_mask   = pl_short ? (6'h3F << (3'd6 - r_bits_left[2:0])) : 6'h3F;
    assign pl_sum    = 7'(i_sextet & pl_mask) + ARMOR_OFS;
    assign pl_char   = (pl_sum > ARMOR_KNEE) ? (pl_sum + ARMOR_GAP) : pl_sum;
    assign pl_fill   = pl_short ? (3'd6 - r_bits_left[2:0]) : 3'd0;
    assign frag_next = r_frag_cnt + FC_W'(1);
    assign pl_close  = pl_last || (frag_next == FC_W'(CHARS_PER_FRAGMENT));
    assign pl_reopen = pl_close && !pl_last;

    always_comb begin
        n_open      = r_open;
        n_bits_left = r_bits_left;
        n_frag_cnt  = r_frag_cnt;
        n_index     = r_index;
        n_total     = r_total;
        n_seq       = r_seq;
        n_chan_b    = r_chan_b;

        o_job           = '0;
        o_job.kind      = JOB_DATA;
        o_job.err       = ERR_NONE;
        o_job.total     = r_total;
        o_job.index     = r_index;
        o_job.seq       = r_seq;
        o_job.chan_b    = r_chan_b;

        if (i_op == OP_START) begin
            if (len_bad) begin
                o_job.kind = JOB_ERR;
                o_job.err  = ERR_LENGTH;
            end else begin
                o_job.kind   = JOB_START;
                o_job.total  = calc_total;
                o_job.index  = 4'd1;
                o_job.seq    = seq_rem[3:0];
                o_job.chan_b = (i_channel == CHAN_B_IN);
            end
        end else if (!r_open) begin
            o_job.kind = JOB_ERR;
            o_job.err  = ERR_NO_MSG;
        end else begin
            o_job.character = pl_char;
            o_job.close     = pl_close;
            o_job.reopen    = pl_reopen;
            o_job.fill      = pl_fill;
            o_job.index     = r_index + 4'd1;
        end

        if (accept) begin
            if (i_op == OP_START) begin
                n_open      = !len_bad;
                n_bits_left = len_bad ? '0 : i_bit_length;
                n_frag_cnt  = '0;
                n_index     = len_bad ? 4'd0 : 4'd1;
                n_total     = len_bad ? 4'd0 : calc_total;
                n_seq       = len_bad ? 4'd0 : seq_rem[3:0];
                n_chan_b    = len_bad ? 1'b0 : (i_channel == CHAN_B_IN);
            end else if (r_open) begin
                n_bits_left = pl_last ? '0 : (r_bits_left - LEN_W'(6));
                n_frag_cnt  = pl_close ? '0 : frag_next;
                if (pl_reopen) begin
                    n_index = r_index + 4'd1;
                end
                if (pl_last) begin
                    n_open   = 1'b0;
                    n_index  = 4'd0;
                    n_total  = 4'd0;
                    n_seq    = 4'd0;
                    n_chan_b = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_bits_left <= '0;
            r_frag_cnt  <= '0;
            r_index     <= '0;
            r_total     <= '0;
            r_seq       <= '0;
            r_chan_b    <= 1'b0;
        end else begin
            r_open      <= n_open;
            r_bits_left <= n_bits_left;
            r_frag_cnt  <= n_frag_cnt;
            r_index     <= n_index;
            r_total     <= n_total;
            r_seq       <= n_seq;
            r_chan_b    <= n_chan_b;
        end
    end

    a_open_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_bits_left != '0))
        else $error("open message with no bits left");

    a_frag_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frag_cnt < FC_W'(CHARS_PER_FRAGMENT))
        else $error("fragment counter past fragment size");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_index != 4'd0) && (r_index <= r_total))
        else $error("fragment index outside fragment total");

endmodule
`default_nettype wire

[rtl/core/asf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asf_queue
// small register fifo of jobs between the front and the back end
// ----------------------------------------------------------------------------
module asf_queue #(
    parameter int DEPTH = asf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  asf_pkg::t_job       i_data,
    output logic                o_full,
    output logic                o_valid,
    output asf_pkg::t_job       o_data,
    input  wire logic           i_pop
);
    import asf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/asf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asf_back
// expands each job into sentence characters, one per cycle unless the
// receiver stalls, keeps the running checksum and drives the output register
// ----------------------------------------------------------------------------
module asf_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  asf_pkg::t_job                    i_q_job,
    output logic                             o_q_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [asf_pkg::CHAR_W-1:0]       o_character,
    output logic                             o_sentence_end,
    output logic                             o_run_last,
    output logic [asf_pkg::ERR_W-1:0]        o_error_code
);
    import asf_pkg::*;

    typedef enum logic [21:0] {
        ST_ERR      = 22'h000001,
        ST_CHAR     = 22'h000002,
        ST_CL_COMMA = 22'h000004,
        ST_CL_FILL  = 22'h000008,
        ST_STAR     = 22'h000010,
        ST_HEX_HI   = 22'h000020,
        ST_HEX_LO   = 22'h000040,
        ST_BANG     = 22'h000080,
        ST_A        = 22'h000100,
        ST_I        = 22'h000200,
        ST_V        = 22'h000400,
        ST_D        = 22'h000800,
        ST_M        = 22'h001000,
        ST_C1       = 22'h002000,
        ST_TOTAL    = 22'h004000,
        ST_C2       = 22'h008000,
        ST_INDEX    = 22'h010000,
        ST_C3       = 22'h020000,
        ST_SEQ      = 22'h040000,
        ST_C4       = 22'h080000,
        ST_CHAN     = 22'h100000,
        ST_C5       = 22'h200000
    } t_step;

    logic              r_active;
    t_job              r_job;
    t_step             r_step;
    logic [7:0]        r_xor;
    logic              r_o_valid;
    logic [CHAR_W-1:0] r_o_char;
    logic              r_o_end;
    logic              r_o_last;
    t_err              r_o_err;

    t_job              cur_job;
    t_step             first_step;
    t_step             cur_step;
    t_step             next_step;
    logic              have;
    logic              emit;
    logic [CHAR_W-1:0] ch;
    logic              ch_end;
    logic              ch_last;
    logic              ch_text;
    logic              ch_clear;
    t_err              ch_err;

    always_comb begin
        unique case (i_q_job.kind)
            JOB_ERR:   first_step = ST_ERR;
            JOB_START: first_step = ST_BANG;
            JOB_DATA:  first_step = ST_CHAR;
            default:   first_step = ST_ERR;
        endcase
    end

    assign cur_job  = r_active ? r_job : i_q_job;
    assign cur_step = r_active ? r_step : first_step;
    assign have     = r_active || i_q_valid;
    assign emit     = have && (!r_o_valid || i_ready);
    assign o_q_pop  = emit && !r_active;

    always_comb begin
        ch        = CH_NUL;
        ch_end    = 1'b0;
        ch_last   = 1'b0;
        ch_text   = 1'b1;
        ch_clear  = 1'b0;
        ch_err    = ERR_NONE;
        next_step = ST_ERR;
        unique case (cur_step)
            ST_ERR: begin
                ch_text = 1'b0;
                ch_err  = cur_job.err;
                ch_last = 1'b1;
            end
            ST_CHAR: begin
                ch        = cur_job.character;
                ch_last   = !cur_job.close;
                next_step = ST_CL_COMMA;
            end
            ST_CL_COMMA: begin
                ch        = CH_COMMA;
                next_step = ST_CL_FILL;
            end
            ST_CL_FILL: begin
                ch        = CH_ZERO + {4'b0000, cur_job.fill};
                next_step = ST_STAR;
            end
            ST_STAR: begin
                ch        = CH_STAR;
                ch_text   = 1'b0;
                next_step = ST_HEX_HI;
            end
            ST_HEX_HI: begin
                ch        = hex_digit(r_xor[7:4]);
                ch_text   = 1'b0;
                next_step = ST_HEX_LO;
            end
            ST_HEX_LO: begin
                ch        = hex_digit(r_xor[3:0]);
                ch_text   = 1'b0;
                ch_end    = 1'b1;
                ch_last   = !cur_job.reopen;
                next_step = ST_BANG;
            end
            ST_BANG: begin
                ch        = CH_BANG;
                ch_text   = 1'b0;
                ch_clear  = 1'b1;
                next_step = ST_A;
            end
            ST_A: begin
                ch        = CH_A;
                next_step = ST_I;
            end
            ST_I: begin
                ch        = CH_I;
                next_step = ST_V;
            end
            ST_V: begin
                ch        = CH_V;
                next_step = ST_D;
            end
            ST_D: begin
                ch        = CH_D;
                next_step = ST_M;
            end
            ST_M: begin
                ch        = CH_M;
                next_step = ST_C1;
            end
            ST_C1: begin
                ch        = CH_COMMA;
                next_step = ST_TOTAL;
            end
            ST_TOTAL: begin
                ch        = CH_ZERO + {3'b000, cur_job.total};
                next_step = ST_C2;
            end
            ST_C2: begin
                ch        = CH_COMMA;
                next_step = ST_INDEX;
            end
            ST_INDEX: begin
                ch        = CH_ZERO + {3'b000, cur_job.index};
                next_step = ST_C3;
            end
            ST_C3: begin
                ch        = CH_COMMA;
                next_step = (cur_job.total > 4'd1) ? ST_SEQ : ST_C4;
            end
            ST_SEQ: begin
                ch        = CH_ZERO + {3'b000, cur_job.seq};
                next_step = ST_C4;
            end
            ST_C4: begin
                ch        = CH_COMMA;
                next_step = ST_CHAN;
            end
            ST_CHAN: begin
                ch        = cur_job.chan_b ? CH_B : CH_A;
                next_step = ST_C5;
            end
            ST_C5: begin
                ch      = CH_COMMA;
                ch_last = 1'b1;
            end
            default: begin
                ch_text = 1'b0;
                ch_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_step    <= ST_ERR;
            r_xor     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_o_valid <= 1'b1;
                if (ch_clear) begin
                    r_xor <= '0;
                end else if (ch_text) begin
                    r_xor <= r_xor ^ {1'b0, ch};
                end
                if (ch_last) begin
                    r_active <= 1'b0;
                end else begin
                    r_active <= 1'b1;
                    r_step   <= next_step;
                end
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_char <= ch;
            r_o_end  <= ch_end;
            r_o_last <= ch_last;
            r_o_err  <= ch_err;
            if (!r_active) begin
                r_job <= i_q_job;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_character    = r_o_char;
    assign o_sentence_end = r_o_end;
    assign o_run_last     = r_o_last;
    assign o_error_code   = r_o_err;

    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_err != ERR_NONE)) |-> (r_o_last && !r_o_end))
        else $error("error beat not a lone last beat");

    a_end_is_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_end) |->
            ((r_o_char >= CH_ZERO) && (r_o_char <= 7'd57))
            || ((r_o_char >= CH_A) && (r_o_char <= 7'd70)))
        else $error("sentence end on a non hex character");

    a_first_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_step != ST_ERR) && (r_step != ST_CHAR))
        else $error("job held on a first-only step");

endmodule
`default_nettype wire

[rtl/core/aivdm_sentence_framer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aivdm_sentence_framer_top
// armors an ais payload into !AIVDM sentence text, one character per beat
//
// input channel: a start beat (op 0) carries bit length, sequence id and
// channel and yields the first header; a payload beat (op 1) carries one
// sextet and yields one armored character, then the ,F*HH close when a
// fragment fills or the message ends, and the next header if bits remain.
// bad starts and payload with no open message yield a single error beat.
// output channel: one ascii character per beat with sentence end, last beat
// of the item and error code.
// path: each job passes through the queue and then the output register.
// throughput: input is taken every cycle while the four-entry (default) job
// queue has room; the back end sequencer emits one character per cycle
// unless the receiver stalls; a full fragment adds the close and next header.
// reset: synchronous active low; clears the open message, the queue and the
// output valid flag; no clearing pass.
// receiver stall: the output register holds its beat, the sequencer waits,
// the queue fills and then input ready drops.
// ----------------------------------------------------------------------------
module aivdm_sentence_framer_top #(
    parameter int MAX_BITS           = asf_pkg::MAX_BITS_DEF,
    parameter int CHARS_PER_FRAGMENT = asf_pkg::CHARS_PER_FRAGMENT_DEF,
    parameter int MAX_FRAGMENTS      = asf_pkg::MAX_FRAGMENTS_DEF,
    parameter int QUEUE_DEPTH        = asf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_op,
    input  wire logic [asf_pkg::LEN_W-1:0]     i_bit_length,
    input  wire logic [asf_pkg::SEQ_W-1:0]     i_seq_id,
    input  wire logic [asf_pkg::CHAN_W-1:0]    i_channel,
    input  wire logic [asf_pkg::SEXTET_W-1:0]  i_sextet,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [asf_pkg::CHAR_W-1:0]         o_character,
    output logic                               o_sentence_end,
    output logic                               o_run_last,
    output logic [asf_pkg::ERR_W-1:0]          o_error_code
);
    import asf_pkg::*;

    logic q_push;
    t_job q_in;
    logic q_full;
    logic q_valid;
    t_job q_head;
    logic q_pop;

    asf_front #(
        .MAX_BITS           (MAX_BITS),
        .CHARS_PER_FRAGMENT (CHARS_PER_FRAGMENT),
        .MAX_FRAGMENTS      (MAX_FRAGMENTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_bit_length (i_bit_length),
        .i_seq_id     (i_seq_id),
        .i_channel    (i_channel),
        .i_sextet     (i_sextet),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_job        (q_in)
    );

    asf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_head),
        .i_pop   (q_pop)
    );

    asf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_job        (q_head),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_character    (o_character),
        .o_sentence_end (o_sentence_end),
        .o_run_last     (o_run_last),
        .o_error_code   (o_error_code)
    );

endmodule
`default_nettype wire
